// ----- rtl/core/dsl_pkg.sv -----
// Shared definitions for the double-step line rasterizer.
// Holds the command codes, move codes and fixed field widths; no dependencies.
package dsl_pkg;

	// Width of the colour field carried through from the start command.
	localparam int COLOR_BITS = 24;

	// Command kinds on the input channel.
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	// Move codes: bit 0 steps the major axis, bit 1 steps the minor axis.
	localparam logic [1:0] MV_NONE = 2'd0;
	localparam logic [1:0] MV_U    = 2'd1;
	localparam logic [1:0] MV_V    = 2'd2;
	localparam logic [1:0] MV_UV   = 2'd3;
	localparam int MV_BIT_U = 0;
	localparam int MV_BIT_V = 1;

	// Pixel buffer geometry: one advance gives at most four pixels.
	localparam int BUF_DEPTH = 4;
	localparam int BUF_IDX_BITS = 2;
	localparam int BUF_CNT_BITS = 3;

endpackage

// ----- rtl/core/dsl_in_if.sv -----
// Command channel of the line rasterizer: valid/ready with one command beat.
// Depends on dsl_pkg for the colour width.
interface dsl_in_if import dsl_pkg::*; #(
	parameter int COORD_BITS = 12
) ();
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [COORD_BITS-1:0] x_start;
	logic [COORD_BITS-1:0] y_start;
	logic [COORD_BITS-1:0] x_end;
	logic [COORD_BITS-1:0] y_end;
	logic [COLOR_BITS-1:0] line_color;

	modport source (
		output valid, kind, x_start, y_start, x_end, y_end, line_color,
		input  ready
	);
	modport sink (
		input  valid, kind, x_start, y_start, x_end, y_end, line_color,
		output ready
	);
endinterface

// ----- rtl/core/dsl_px_if.sv -----
// Pixel channel of the line rasterizer: valid/ready with one pixel per beat.
// Depends on dsl_pkg for the colour width.
interface dsl_px_if import dsl_pkg::*; #(
	parameter int COORD_BITS = 12
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  run_last;
	logic                  line_last;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, run_last, line_last,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, run_last, line_last,
		output ready
	);
endinterface

// ----- rtl/core/double_step_line_rasterizer_top.sv -----
// Symmetric double-step line rasterizer. A start command gives both endpoints (one pixel
// for a point); each advance command gives four pixels, two from each end, and the last
// advance gives the one to three pixels that remain. Commands are registered, worked
// through combinationally into a four-entry pixel buffer, and pixels leave one per beat
// while the pixel side is ready: the single pixel port sets the rate. A command passes the
// command register, then the pixel buffer, before its first pixel appears, and the next
// command is taken while the buffer still drains. Uses dsl_pkg, dsl_in_if and dsl_px_if.
module double_step_line_rasterizer_top import dsl_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	dsl_in_if.sink   cmd,
	dsl_px_if.source pix
);

	localparam int CW = COORD_BITS;
	localparam int DW = COORD_BITS + 5;
	localparam int SW = COORD_BITS - 2;

	// Move a coordinate by a small count, wrapping modulo the coordinate range.
	function automatic logic [CW-1:0] nudge_by(input logic [CW-1:0] v, input logic [1:0] n,
			input logic back);
		logic [CW-1:0] amt;
		amt = {{(CW-2){1'b0}}, n};
		return back ? v - amt : v + amt;
	endfunction

	// Pick the major or minor step count for one axis and apply it.
	function automatic logic [CW-1:0] move_axis(input logic [CW-1:0] v, input logic [1:0] du,
			input logic [1:0] dv, input logic minor, input logic back);
		return nudge_by(v, minor ? dv : du, back);
	endfunction

	// Command register.
	logic                  valid_s1;
	logic                  kind_s1;
	logic [CW-1:0]         xs_s1, ys_s1, xe_s1, ye_s1;
	logic [COLOR_BITS-1:0] color_s1;

	// Line state.
	logic                  active_q;
	logic [CW-1:0]         near_x_q, near_y_q, far_x_q, far_y_q;
	logic                  x_back_q, y_back_q, y_major_q, steep_q;
	logic signed [DW-1:0]  dec_q, thr_q, inc1_q, inc2_q;
	logic [SW-1:0]         steps_q;
	logic [1:0]            tail_q;
	logic [COLOR_BITS-1:0] color_q;

	// Pixel buffer.
	logic [CW-1:0]           bx_q [BUF_DEPTH];
	logic [CW-1:0]           by_q [BUF_DEPTH];
	logic [COLOR_BITS-1:0]   bcol_q;
	logic [BUF_CNT_BITS-1:0] bcnt_q;
	logic [BUF_IDX_BITS-1:0] bidx_q;
	logic                    bline_q;

	logic pix_fire, buf_last, buf_free, take_s1;

	// Output side: the buffer drains one pixel per beat.
	assign pix_fire = pix.valid && pix.ready;
	assign buf_last = ({1'b0, bidx_q} + 3'd1) == bcnt_q;
	assign buf_free = (bcnt_q == '0) || (pix_fire && buf_last);
	assign take_s1  = valid_s1 && buf_free;
	assign cmd.ready = !valid_s1 || take_s1;

	assign pix.valid       = bcnt_q != '0;
	assign pix.pixel_x     = bx_q[bidx_q];
	assign pix.pixel_y     = by_q[bidx_q];
	assign pix.pixel_color = bcol_q;
	assign pix.run_last    = buf_last;
	assign pix.line_last   = buf_last && bline_q;

	// Command register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			kind_s1  <= cmd.kind;
			xs_s1    <= cmd.x_start;
			ys_s1    <= cmd.y_start;
			xe_s1    <= cmd.x_end;
			ye_s1    <= cmd.y_end;
			color_s1 <= cmd.line_color;
		end
	end

	// Line setup from the two endpoints.
	logic signed [CW:0]   dx, dy;
	logic [CW-1:0]        adx, ady, dmaj, dmin, dm1;
	logic                 st_xb, st_yb, st_point, st_ymaj, st_steep, st_short;
	logic signed [DW-1:0] smaj, smin, st_inc2, st_thr, st_inc1, st_dec;

	always_comb begin
		dx = $signed({1'b0, xe_s1}) - $signed({1'b0, xs_s1});
		dy = $signed({1'b0, ye_s1}) - $signed({1'b0, ys_s1});
		st_xb = dx[CW];
		st_yb = dy[CW];
		adx = st_xb ? CW'(-dx) : dx[CW-1:0];
		ady = st_yb ? CW'(-dy) : dy[CW-1:0];
		st_point = (adx == '0) && (ady == '0);
		st_ymaj = adx <= ady;
		dmaj = st_ymaj ? ady : adx;
		dmin = st_ymaj ? adx : ady;
		dm1 = dmaj - CW'(1);
		st_short = dm1 == '0;
		smaj = $signed({{(DW-CW){1'b0}}, dmaj});
		smin = $signed({{(DW-CW){1'b0}}, dmin});
		st_inc2 = (smin <<< 2) - (smaj <<< 1);
		st_steep = !st_inc2[DW-1];
		st_thr = st_steep ? ((smin - smaj) <<< 1) : (smin <<< 1);
		st_inc1 = st_thr <<< 1;
		st_dec = st_steep ? (st_inc1 + smaj) : (st_inc1 - smaj);
	end

	// One double step, or the final step, from the stored state.
	logic                 cond, d_lt_c, d_gt_c, dbl;
	logic [1:0]           mv_first, mv_second, m1, m2, m3;
	logic [1:0]           na_u, na_v, nb_u, nb_v, fa_u, fa_v, fb_u, fb_v;
	logic signed [DW-1:0] adv_dec;
	logic [CW-1:0]        na_x, na_y, nb_x, nb_y, fa_x, fa_y, fb_x, fb_y;

	always_comb begin
		cond = steep_q ? (dec_q > 0) : (dec_q < 0);
		d_lt_c = dec_q < thr_q;
		d_gt_c = dec_q > thr_q;
		dbl = steps_q != '0;

		// Double step: both ends take one major step, then a pair of moves.
		if (cond) begin
			mv_first  = steep_q ? MV_V : MV_NONE;
			mv_second = steep_q ? MV_UV : MV_U;
			adv_dec   = dec_q + inc1_q;
		end else if (d_lt_c) begin
			mv_first  = MV_NONE;
			mv_second = MV_UV;
			adv_dec   = dec_q + inc2_q;
		end else begin
			mv_first  = MV_V;
			mv_second = MV_U;
			adv_dec   = dec_q + inc2_q;
		end

		// Final step: up to two moves at the near end and one at the far end.
		if (cond) begin
			m1 = steep_q ? MV_UV : MV_U;
			m2 = m1;
			m3 = m1;
		end else if (d_lt_c) begin
			m1 = MV_U;
			m2 = MV_UV;
			m3 = MV_U;
		end else begin
			m1 = MV_UV;
			m2 = MV_U;
			m3 = (!steep_q || d_gt_c) ? MV_UV : MV_U;
		end

		// Step counts from each end for both pixels of the run.
		if (dbl) begin
			na_u = 2'd1 + {1'b0, mv_first[MV_BIT_U]};
			na_v = {1'b0, mv_first[MV_BIT_V]};
			nb_u = na_u + {1'b0, mv_second[MV_BIT_U]};
			nb_v = na_v + {1'b0, mv_second[MV_BIT_V]};
			fa_u = na_u;
			fa_v = na_v;
			fb_u = nb_u;
			fb_v = nb_v;
		end else begin
			na_u = {1'b0, m1[MV_BIT_U]};
			na_v = {1'b0, m1[MV_BIT_V]};
			nb_u = na_u + {1'b0, m2[MV_BIT_U]};
			nb_v = na_v + {1'b0, m2[MV_BIT_V]};
			fa_u = {1'b0, m3[MV_BIT_U]};
			fa_v = {1'b0, m3[MV_BIT_V]};
			fb_u = fa_u;
			fb_v = fa_v;
		end

		// The far end walks back towards the near end.
		na_x = move_axis(near_x_q, na_u, na_v, y_major_q, x_back_q);
		na_y = move_axis(near_y_q, na_u, na_v, !y_major_q, y_back_q);
		nb_x = move_axis(near_x_q, nb_u, nb_v, y_major_q, x_back_q);
		nb_y = move_axis(near_y_q, nb_u, nb_v, !y_major_q, y_back_q);
		fa_x = move_axis(far_x_q, fa_u, fa_v, y_major_q, !x_back_q);
		fa_y = move_axis(far_y_q, fa_u, fa_v, !y_major_q, !y_back_q);
		fb_x = move_axis(far_x_q, fb_u, fb_v, y_major_q, !x_back_q);
		fb_y = move_axis(far_y_q, fb_u, fb_v, !y_major_q, !y_back_q);
	end

	// Control state and buffer occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bcnt_q   <= '0;
			bidx_q   <= '0;
		end else begin
			if (pix_fire) begin
				if (buf_last) begin
					bcnt_q <= '0;
					bidx_q <= '0;
				end else begin
					bidx_q <= bidx_q + BUF_IDX_BITS'(1);
				end
			end
			if (take_s1) begin
				if (kind_s1 == KIND_START) begin
					active_q <= !st_point && !st_short;
					bcnt_q   <= st_point ? BUF_CNT_BITS'(1) : BUF_CNT_BITS'(2);
				end else if (active_q) begin
					if (dbl) begin
						active_q <= !((steps_q == SW'(1)) && (tail_q == '0));
						bcnt_q   <= BUF_CNT_BITS'(BUF_DEPTH);
					end else begin
						active_q <= 1'b0;
						bcnt_q   <= {1'b0, tail_q};
					end
				end
			end
		end
	end

	// Line registers and buffer contents.
	always_ff @(posedge clk) begin
		if (take_s1) begin
			if (kind_s1 == KIND_START) begin
				near_x_q  <= xs_s1;
				near_y_q  <= ys_s1;
				far_x_q   <= xe_s1;
				far_y_q   <= ye_s1;
				x_back_q  <= st_xb;
				y_back_q  <= st_yb;
				y_major_q <= st_ymaj;
				steep_q   <= st_steep;
				dec_q     <= st_dec;
				thr_q     <= st_thr;
				inc1_q    <= st_inc1;
				inc2_q    <= st_inc2;
				steps_q   <= dm1[CW-1:2];
				tail_q    <= dm1[1:0];
				color_q   <= color_s1;
				bx_q[0]   <= xs_s1;
				by_q[0]   <= ys_s1;
				bx_q[1]   <= xe_s1;
				by_q[1]   <= ye_s1;
				bcol_q    <= color_s1;
				bline_q   <= st_point || st_short;
			end else if (active_q) begin
				bx_q[0] <= na_x;
				by_q[0] <= na_y;
				bx_q[1] <= nb_x;
				by_q[1] <= nb_y;
				bx_q[2] <= fa_x;
				by_q[2] <= fa_y;
				bx_q[3] <= fb_x;
				by_q[3] <= fb_y;
				bcol_q  <= color_q;
				if (dbl) begin
					near_x_q <= nb_x;
					near_y_q <= nb_y;
					far_x_q  <= fb_x;
					far_y_q  <= fb_y;
					dec_q    <= adv_dec;
					steps_q  <= steps_q - SW'(1);
					bline_q  <= (steps_q == SW'(1)) && (tail_q == '0);
				end else begin
					tail_q  <= '0;
					bline_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/dsl_checker.sv -----
// Port-level checks for the line rasterizer, attached to the top level by bind.
// Depends on dsl_pkg and on the top level's pixel channel signals.
module dsl_checker import dsl_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  px_valid,
	input logic                  px_ready,
	input logic [COORD_BITS-1:0] px_x,
	input logic [COORD_BITS-1:0] px_y,
	input logic [COLOR_BITS-1:0] px_color,
	input logic                  px_run_last
);

	logic                  beat;
	logic [1:0]            run_cnt_q;
	logic [COLOR_BITS-1:0] col_q;

	assign beat = px_valid && px_ready;

	// Count beats within one run and remember the colour of the previous beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (beat) begin
			run_cnt_q <= px_run_last ? 2'd0 : run_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			col_q <= px_color;
		end
	end

	// A pixel offered but not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		px_valid && !px_ready |=> px_valid)
		else $error("pixel valid dropped while stalled");

	// A stalled pixel keeps its coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		px_valid && !px_ready |=> $stable(px_x) && $stable(px_y))
		else $error("pixel coordinates changed while stalled");

	// No command gives more than four pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		beat && run_cnt_q == 2'd3 |-> px_run_last)
		else $error("run longer than four pixels");

	// All pixels of one run carry the same colour.
	assert property (@(posedge clk) disable iff (!arst_n)
		beat && run_cnt_q != 2'd0 |-> px_color == col_q)
		else $error("colour changed within a run");

	// Nothing is offered while reset is held.
	assert property (@(posedge clk) !arst_n |-> !px_valid)
		else $error("pixel offered during reset");

endmodule

bind double_step_line_rasterizer_top dsl_checker #(
	.COORD_BITS(COORD_BITS)
) u_dsl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.px_valid    (pix.valid),
	.px_ready    (pix.ready),
	.px_x        (pix.pixel_x),
	.px_y        (pix.pixel_y),
	.px_color    (pix.pixel_color),
	.px_run_last (pix.run_last)
);

// ----- test/tb_top.sv -----
// Self-checking bench for the double-step line rasterizer: a directed table of lines, then
// random lines, with every pixel beat checked against table rows or a behavioural model held here.
// Depends on dsl_pkg, dsl_in_if, dsl_px_if and double_step_line_rasterizer_top.
`timescale 1ns / 100ps

module tb_top import dsl_pkg::*;;

	localparam int CB = 12;
	localparam int MAXC = (1 << CB) - 1;
	localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
	localparam int RANDOM_ITEMS = 480;

	typedef logic [CB-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	typedef struct packed {
		logic   kind;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
		color_t color;
	} cmd_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   run_last;
		logic   line_last;
	} pixel_t;

	// A row of the directed table; n < 0 means the model works out the pixels.
	typedef struct {
		cmd_t   c;
		int     n;
		pixel_t p0;
		pixel_t p1;
	} row_t;

	logic clk;
	logic arst_n;
	int   errors;
	bit   hold_req;
	bit   quiet;

	dsl_in_if #(.COORD_BITS(CB)) cmd_if ();
	dsl_px_if #(.COORD_BITS(CB)) px_if ();

	double_step_line_rasterizer_top #(.COORD_BITS(CB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.pix    (px_if)
	);

	// Line state of the behavioural model.
	bit     ln_active;
	coord_t near_x, near_y, far_x, far_y;
	bit     x_back, y_back, y_major, steep;
	int     dec, thr, inc_one, inc_two;
	int     steps_left, tail;
	color_t ln_color;

	pixel_t burst[$];
	pixel_t pixels_due[$];
	row_t   script[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net in case the pipeline locks up.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic coord_t nudge(coord_t v, bit back);
		coord_t r;
		r = back ? v - coord_t'(1) : v + coord_t'(1);
		return r;
	endfunction

	// Move one end; the far end walks back towards the near end.
	task automatic move_end(bit far_end, logic [1:0] m);
		bit bx, by, mx, my;
		bx = x_back ^ far_end;
		by = y_back ^ far_end;
		mx = y_major ? m[MV_BIT_V] : m[MV_BIT_U];
		my = y_major ? m[MV_BIT_U] : m[MV_BIT_V];
		if (far_end) begin
			if (mx) far_x = nudge(far_x, bx);
			if (my) far_y = nudge(far_y, by);
		end else begin
			if (mx) near_x = nudge(near_x, bx);
			if (my) near_y = nudge(near_y, by);
		end
	endtask

	task automatic put_end(bit far_end);
		pixel_t p;
		p.x = far_end ? far_x : near_x;
		p.y = far_end ? far_y : near_y;
		p.color = ln_color;
		p.run_last = 1'b0;
		p.line_last = 1'b0;
		burst.push_back(p);
	endtask

	task automatic move_pair(bit far_end, logic [1:0] first, logic [1:0] second);
		if (first != MV_NONE) move_end(far_end, first);
		put_end(far_end);
		move_end(far_end, second);
		put_end(far_end);
	endtask

	// Advances the model by one command and leaves the pixels it causes in burst.
	task automatic trace_command(cmd_t c);
		int x0, y0, x1, y1, dx, dy, dmaj, dmin, inc2, d, t;
		logic [1:0] first, second, m1, m2, m3;
		bit ends;
		burst.delete();
		ends = 1'b0;
		if (c.kind == KIND_START) begin
			x0 = int'(c.xs);
			y0 = int'(c.ys);
			x1 = int'(c.xe);
			y1 = int'(c.ye);
			dx = x1 - x0;
			dy = y1 - y0;
			ln_color = c.color;
			near_x = c.xs;
			near_y = c.ys;
			far_x = c.xe;
			far_y = c.ye;
			x_back = dx < 0;
			y_back = dy < 0;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx == 0 && dy == 0) begin
				// A point gives a single pixel and leaves the block idle.
				put_end(1'b0);
				ends = 1'b1;
			end else begin
				y_major = !(dx > dy);
				dmaj = y_major ? dy : dx;
				dmin = y_major ? dx : dy;
				steps_left = (dmaj - 1) / 4;
				tail = (dmaj - 1) % 4;
				inc2 = dmin * 4 - dmaj * 2;
				steep = inc2 >= 0;
				inc_two = inc2;
				thr = steep ? (dmin - dmaj) * 2 : dmin * 2;
				inc_one = thr * 2;
				dec = steep ? inc_one + dmaj : inc_one - dmaj;
				ln_active = 1'b1;
				put_end(1'b0);
				put_end(1'b1);
				ends = steps_left == 0 && tail == 0;
			end
		end else if (!ln_active) begin
			// An advance with no line in progress gives nothing.
		end else if (steps_left > 0) begin
			// One double step from each end.
			d = dec;
			t = thr;
			move_end(1'b0, MV_U);
			move_end(1'b1, MV_U);
			if (steep ? d > 0 : d < 0) begin
				first = steep ? MV_V : MV_NONE;
				second = steep ? MV_UV : MV_U;
				dec = d + inc_one;
			end else begin
				if (d < t) begin
					first = MV_NONE;
					second = MV_UV;
				end else begin
					first = MV_V;
					second = MV_U;
				end
				dec = d + inc_two;
			end
			move_pair(1'b0, first, second);
			move_pair(1'b1, first, second);
			steps_left--;
			ends = steps_left == 0 && tail == 0;
		end else begin
			// Final step: one to three pixels that remain in the middle.
			d = dec;
			t = thr;
			if (steep ? d > 0 : d < 0) begin
				m1 = steep ? MV_UV : MV_U;
				m2 = m1;
				m3 = m1;
			end else if (d < t) begin
				m1 = MV_U;
				m2 = MV_UV;
				m3 = MV_U;
			end else begin
				m1 = MV_UV;
				m2 = MV_U;
				m3 = (!steep || d > t) ? MV_UV : MV_U;
			end
			move_end(1'b0, m1);
			put_end(1'b0);
			if (tail > 1) begin
				move_end(1'b0, m2);
				put_end(1'b0);
			end
			if (tail > 2) begin
				move_end(1'b1, m3);
				put_end(1'b1);
			end
			tail = 0;
			ends = 1'b1;
		end
		if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
		if (ends) begin
			ln_active = 1'b0;
			burst[burst.size() - 1].line_last = 1'b1;
		end
	endtask

	function automatic cmd_t mk(logic k, int xs, int ys, int xe, int ye, int col);
		cmd_t c;
		c.kind = k;
		c.xs = coord_t'(xs);
		c.ys = coord_t'(ys);
		c.xe = coord_t'(xe);
		c.ye = coord_t'(ye);
		c.color = color_t'(col);
		return c;
	endfunction

	function automatic pixel_t px(int x, int y, int col, bit rl, bit ll);
		pixel_t p;
		p.x = coord_t'(x);
		p.y = coord_t'(y);
		p.color = color_t'(col);
		p.run_last = rl;
		p.line_last = ll;
		return p;
	endfunction

	task automatic add(cmd_t c, int n = -1, pixel_t p0 = '0, pixel_t p1 = '0);
		row_t r;
		r.c = c;
		r.n = n;
		r.p0 = p0;
		r.p1 = p1;
		script.push_back(r);
	endtask

	// Offers one command beat and waits for it to be taken; the model runs on acceptance.
	task automatic deliver(cmd_t c, bit keep, output int n);
		cmd_if.valid <= 1'b1;
		cmd_if.kind <= c.kind;
		cmd_if.x_start <= c.xs;
		cmd_if.y_start <= c.ys;
		cmd_if.x_end <= c.xe;
		cmd_if.y_end <= c.ye;
		cmd_if.line_color <= c.color;
		do @(posedge clk); while (!cmd_if.ready);
		trace_command(c);
		n = burst.size();
		if (keep) begin
			foreach (burst[i]) pixels_due.push_back(burst[i]);
		end
	endtask

	// Random gap on the command side, except in the quiet stretch.
	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 99) < 9) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Lowers valid and waits for every expected pixel.
	task automatic drain();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (pixels_due.size() != 0);
	endtask

	// A coordinate a short way from base, reflected back into range.
	function automatic coord_t near_coord(coord_t base, int span);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0 || v > MAXC) v = 2 * int'(base) - v;
		return coord_t'(v);
	endfunction

	function automatic cmd_t random_cmd(logic k);
		return mk(k, $urandom_range(0, MAXC), $urandom_range(0, MAXC),
			$urandom_range(0, MAXC), $urandom_range(0, MAXC), $urandom_range(0, COLOR_MAX));
	endfunction

	// Pixel side: check every beat taken, and stall at random.
	task automatic field_ok(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pixels_due.size() == 0) begin
			$display("%0t: pixel (%0d,%0d) with none expected, expected nothing, actual beat",
				$time, px_if.pixel_x, px_if.pixel_y);
			errors++;
			return;
		end
		want = pixels_due.pop_front();
		field_ok("pixel_x", want.x, px_if.pixel_x);
		field_ok("pixel_y", want.y, px_if.pixel_y);
		field_ok("pixel_color", want.color, px_if.pixel_color);
		field_ok("run_last", want.run_last, px_if.run_last);
		field_ok("line_last", want.line_last, px_if.line_last);
	endtask

	initial begin
		int hold;
		hold = 0;
		px_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (px_if.valid === 1'b1 && px_if.ready) check_pixel();
			if (hold_req) begin
				hold_req = 1'b0;
				hold = 80;
			end
			if (hold > 0) begin
				hold--;
				px_if.ready <= 1'b0;
			end else begin
				px_if.ready <= quiet || $urandom_range(0, 99) >= 9;
			end
		end
	end

	// Command side: reset, directed table, then random lines.
	initial begin
		int n, need, busy, pick;
		bit big, paused;
		cmd_t c;
		coord_t bx, by;
		int span_x, span_y;
		errors = 0;
		hold_req = 1'b0;
		quiet = 1'b0;
		paused = 1'b0;
		busy = 0;
		ln_active = 1'b0;
		near_x = '0;
		near_y = '0;
		far_x = '0;
		far_y = '0;
		x_back = 1'b0;
		y_back = 1'b0;
		y_major = 1'b0;
		steep = 1'b0;
		dec = 0;
		thr = 0;
		inc_one = 0;
		inc_two = 0;
		steps_left = 0;
		tail = 0;
		ln_color = '0;
		arst_n <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.kind <= KIND_START;
		cmd_if.x_start <= '0;
		cmd_if.y_start <= '0;
		cmd_if.x_end <= '0;
		cmd_if.y_end <= '0;
		cmd_if.line_color <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Advance straight after reset gives nothing.
		add(mk(KIND_ADVANCE, MAXC, MAXC, MAXC, MAXC, COLOR_MAX), 0);
		// Points at both corners, then an advance with no line.
		add(mk(KIND_START, 0, 0, 0, 0, 0), 1, px(0, 0, 0, 1, 1));
		add(mk(KIND_START, MAXC, MAXC, MAXC, MAXC, COLOR_MAX), 1,
			px(MAXC, MAXC, COLOR_MAX, 1, 1));
		add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0), 0);
		// A line one pixel long is finished by its start.
		add(mk(KIND_START, 0, 0, 1, 0, 'h123456), 2, px(0, 0, 'h123456, 0, 0),
			px(1, 0, 'h123456, 1, 1));
		// Full-height vertical line, dropped part way by a new start.
		add(mk(KIND_START, MAXC, 0, MAXC, MAXC, 'hABCDEF), 2, px(MAXC, 0, 'hABCDEF, 0, 0),
			px(MAXC, MAXC, 'hABCDEF, 1, 0));
		add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		add(mk(KIND_START, 0, MAXC, MAXC, 0, 'h0F0F0F), 2, px(0, MAXC, 'h0F0F0F, 0, 0),
			px(MAXC, 0, 'h0F0F0F, 1, 0));
		add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		// Horizontal line run to its end, then one advance too many.
		add(mk(KIND_START, 0, 5, 12, 5, 'h00FF00));
		repeat (3) add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0), 0);
		// Backward vertical with a two-pixel tail.
		add(mk(KIND_START, 7, 100, 7, 93, 'h800000));
		repeat (2) add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		// Shallow and steep branches, and a line of two major steps.
		add(mk(KIND_START, 10, 10, 19, 13, 'h000080));
		repeat (2) add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		add(mk(KIND_START, 30, 30, 25, 21, 'h008080));
		repeat (2) add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));
		add(mk(KIND_START, 50, 50, 52, 51, 'h808000));
		add(mk(KIND_ADVANCE, 0, 0, 0, 0, 0));

		foreach (script[i]) begin
			deliver(script[i].c, script[i].n < 0, n);
			if (script[i].n > 0) pixels_due.push_back(script[i].p0);
			if (script[i].n > 1) pixels_due.push_back(script[i].p1);
			maybe_gap();
		end
		drain();

		// Random lines; the pixel side holds off for a while at the outset.
		hold_req = 1'b1;
		while (busy < RANDOM_ITEMS) begin
			quiet = busy >= 200 && busy < 300;
			if (!paused && busy >= 350) begin
				paused = 1'b1;
				drain();
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// Noise: a lone command of either kind with random fields.
				c = random_cmd($urandom_range(0, 1));
				deliver(c, 1'b1, n);
				if (n > 0) busy++;
				maybe_gap();
			end else begin
				big = $urandom_range(0, 11) == 0;
				if (big) begin
					c = random_cmd(KIND_START);
				end else begin
					bx = coord_t'($urandom_range(0, MAXC));
					by = coord_t'($urandom_range(0, MAXC));
					span_x = $urandom_range(0, 40);
					span_y = $urandom_range(0, 40);
					c = mk(KIND_START, bx, by, near_coord(bx, span_x), near_coord(by, span_y),
						$urandom_range(0, COLOR_MAX));
				end
				deliver(c, 1'b1, n);
				busy++;
				maybe_gap();
				need = ln_active ? steps_left + (tail != 0) : 0;
				if (big || pick < 20) begin
					// Broken sequence: the line may be cut short by the next start.
					need = $urandom_range(0, (need < 10) ? need : 10);
				end else if ($urandom_range(0, 5) == 0) begin
					need++;
				end
				repeat (need) begin
					deliver(random_cmd(KIND_ADVANCE), 1'b1, n);
					if (n > 0) busy++;
					maybe_gap();
				end
			end
		end
		quiet = 1'b0;
		drain();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
